// ===== hw/rtl/vlus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlus_pkg
// Types and constants shared by the vector limit uniform scaler.
// ----------------------------------------------------------------------------
package vlus_pkg;

   localparam int LANES           = 3;
   localparam int VALUE_W         = 16;
   localparam int LIMIT_W         = 15;
   localparam int CSR_IDX_W       = 2;
   localparam int JOINTS_DEF      = 3;
   localparam int RATIO_FRAC_DEF  = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_JOINT0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_JOINT1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_JOINT2 = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_joint0;
      logic signed [VALUE_W-1:0] value_joint1;
      logic signed [VALUE_W-1:0] value_joint2;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] scaled_joint0;
      logic signed [VALUE_W-1:0] scaled_joint1;
      logic signed [VALUE_W-1:0] scaled_joint2;
      logic                      was_scaled;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/vlus_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlus_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface vlus_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/vlus_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlus_lane
// One joint lane: saturated magnitude and a one-bit-per-stage pipelined
// divider forming limit / |value|, clamped to one.
// ----------------------------------------------------------------------------
module vlus_lane #(
   parameter int RATIO_FRAC_BITS = vlus_pkg::RATIO_FRAC_DEF
) (
   input  logic                                clock,
   input  logic [RATIO_FRAC_BITS:0]            en,
   input  logic signed [vlus_pkg::VALUE_W-1:0] value_in,
   input  logic [vlus_pkg::LIMIT_W-1:0]        limit_in,
   output logic [RATIO_FRAC_BITS:0]            ratio_out,
   output logic signed [vlus_pkg::VALUE_W-1:0] value_out
);
   import vlus_pkg::*;

   localparam int F = RATIO_FRAC_BITS;

   logic signed [VALUE_W-1:0] v_ff   [F+1];
   logic [LIMIT_W-1:0]        m_ff   [F+1];
   logic [LIMIT_W-1:0]        rem_ff [F+1];
   logic [F-1:0]              q_ff   [F+1];
   logic                      big_ff [F+1];

   logic [VALUE_W-1:0] abs_val;
   logic [LIMIT_W-1:0] mag;

   always_comb begin
      abs_val = value_in[VALUE_W-1] ? VALUE_W'(-value_in) : VALUE_W'(value_in);
      mag     = abs_val[VALUE_W-1] ? LIMIT_MAX : abs_val[LIMIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v_ff[0]   <= value_in;
         m_ff[0]   <= mag;
         rem_ff[0] <= limit_in;
         q_ff[0]   <= '0;
         big_ff[0] <= (mag == '0) || (limit_in >= mag);
      end
   end

   for (genvar k = 1; k <= F; k++) begin : g_step
      logic [LIMIT_W:0]   rem2;
      logic               ge;
      logic [LIMIT_W-1:0] rem_in;
      logic [F-1:0]       q_in;

      always_comb begin
         rem2   = {rem_ff[k-1], 1'b0};
         ge     = rem2 >= {1'b0, m_ff[k-1]};
         rem_in = ge ? LIMIT_W'(rem2 - {1'b0, m_ff[k-1]}) : rem2[LIMIT_W-1:0];
         q_in   = {q_ff[k-1][F-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            v_ff[k]   <= v_ff[k-1];
            m_ff[k]   <= m_ff[k-1];
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            big_ff[k] <= big_ff[k-1];
         end
      end
   end

   assign ratio_out = big_ff[F] ? {1'b1, {F{1'b0}}} : {1'b0, q_ff[F]};
   assign value_out = v_ff[F];

endmodule

// ===== hw/rtl/vlus_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlus_merge
// Takes the smallest lane ratio and decides whether the vector is scaled.
// ----------------------------------------------------------------------------
module vlus_merge #(
   parameter int JOINTS          = vlus_pkg::JOINTS_DEF,
   parameter int RATIO_FRAC_BITS = vlus_pkg::RATIO_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [RATIO_FRAC_BITS:0]            ratio_in [JOINTS],
   input  logic signed [vlus_pkg::VALUE_W-1:0] value_in [JOINTS],
   output logic [RATIO_FRAC_BITS-1:0]          best_out,
   output logic                                scale_out,
   output logic signed [vlus_pkg::VALUE_W-1:0] value_out [JOINTS]
);
   import vlus_pkg::*;

   localparam int F = RATIO_FRAC_BITS;

   logic [F:0]                best;
   logic [F-1:0]              best_ff;
   logic                      scale_ff;
   logic signed [VALUE_W-1:0] v_ff [JOINTS];

   always_comb begin
      best = {1'b1, {F{1'b0}}};
      for (int j = 0; j < JOINTS; j++) begin
         if (ratio_in[j] < best) begin
            best = ratio_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         best_ff  <= best[F-1:0];
         scale_ff <= !best[F];
         v_ff     <= value_in;
      end
   end

   assign best_out  = best_ff;
   assign scale_out = scale_ff;
   assign value_out = v_ff;

endmodule

// ===== hw/rtl/vlus_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlus_scale
// Per-lane multiply by the common ratio, truncated toward zero (value passed
// through unchanged when not scaled), then the output register.
// ----------------------------------------------------------------------------
module vlus_scale #(
   parameter int RATIO_FRAC_BITS = vlus_pkg::RATIO_FRAC_DEF
) (
   input  logic                                clock,
   input  logic [1:0]                          en,
   input  logic [RATIO_FRAC_BITS-1:0]          best_in,
   input  logic                                scale_in,
   input  logic signed [vlus_pkg::VALUE_W-1:0] value_in,
   output logic signed [vlus_pkg::VALUE_W-1:0] result_out
);
   import vlus_pkg::*;

   localparam int F = RATIO_FRAC_BITS;

   logic [VALUE_W-1:0]        abs_val;
   logic [VALUE_W+F-1:0]      prod_ff;
   logic                      neg_ff;
   logic                      scale_ff;
   logic signed [VALUE_W-1:0] v_ff;
   logic [VALUE_W-1:0]        p;
   logic signed [VALUE_W-1:0] res_in;
   logic signed [VALUE_W-1:0] res_ff;

   assign abs_val = value_in[VALUE_W-1] ? VALUE_W'(-value_in) : VALUE_W'(value_in);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff  <= (VALUE_W+F)'(abs_val) * (VALUE_W+F)'(best_in);
         neg_ff   <= value_in[VALUE_W-1];
         scale_ff <= scale_in;
         v_ff     <= value_in;
      end
   end

   always_comb begin
      p = prod_ff[F +: VALUE_W];
      if (!scale_ff) begin
         res_in = v_ff;
      end else if (neg_ff) begin
         res_in = -$signed(p);
      end else begin
         res_in = $signed(p);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         res_ff <= res_in;
      end
   end

   assign result_out = res_ff;

endmodule

// ===== hw/rtl/vector_limit_uniform_scaler_unit.sv =====
`timescale 1ns / 1ps
// pipeline: lane divider stages, merge register, then scale product and output registers
// throughput: one vector per cycle; each lane divider resolves one quotient bit per stage
// a stalled result holds the pipeline back only once every stage is occupied
// reset: synchronous, clears all stage valid bits and sets every joint limit to 32767
// ----------------------------------------------------------------------------
// vector_limit_uniform_scaler_unit
// Direction-preserving saturation of a three-joint Q7.8 vector against
// per-joint magnitude limits.
// ----------------------------------------------------------------------------
module vector_limit_uniform_scaler_unit #(
   parameter int JOINTS          = vlus_pkg::JOINTS_DEF,
   parameter int RATIO_FRAC_BITS = vlus_pkg::RATIO_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   vlus_stream_if.sink                      req_chan,
   vlus_stream_if.source                    rsp_chan,
   input  logic                             csr_we,
   input  logic [vlus_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vlus_pkg::LIMIT_W-1:0]     csr_wdata
);
   import vlus_pkg::*;

   localparam int F = RATIO_FRAC_BITS;
   localparam int S = F + 4;

   logic [LIMIT_W-1:0] lim_ff [LANES];

   logic [S-1:0] vld_ff;
   logic [S-1:0] vld_in;
   logic [S:0]   rdy;

   logic signed [VALUE_W-1:0] val_s   [LANES];
   logic [F:0]                ratio_s [JOINTS];
   logic signed [VALUE_W-1:0] lane_v  [JOINTS];
   logic signed [VALUE_W-1:0] mrg_v   [JOINTS];
   logic signed [VALUE_W-1:0] res_s   [LANES];
   logic [F-1:0]              best_s;
   logic                      scale_s;
   logic                      scl_a_ff;
   logic                      scl_b_ff;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LANES; j++) begin
            lim_ff[j] <= LIMIT_MAX;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIMIT_JOINT0: lim_ff[0] <= csr_wdata;
            CSR_LIMIT_JOINT1: lim_ff[1] <= csr_wdata;
            CSR_LIMIT_JOINT2: lim_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage flow control, bubbles collapse
   always_comb begin
      rdy[S] = rsp_chan.ready;
      for (int k = S - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < S; k++) begin
         if (rdy[k]) begin
            vld_in[k] = (k == 0) ? req_chan.valid : vld_ff[(k == 0) ? 0 : k - 1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = rdy[0];
   assign rsp_chan.valid = vld_ff[S-1];

   assign val_s[0] = req_chan.payload.value_joint0;
   assign val_s[1] = req_chan.payload.value_joint1;
   assign val_s[2] = req_chan.payload.value_joint2;

   for (genvar j = 0; j < JOINTS; j++) begin : g_lane
      vlus_lane #(
         .RATIO_FRAC_BITS (F)
      ) u_lane (
         .clock     (clock),
         .en        (rdy[F:0]),
         .value_in  (val_s[j]),
         .limit_in  (lim_ff[j]),
         .ratio_out (ratio_s[j]),
         .value_out (lane_v[j])
      );
   end

   vlus_merge #(
      .JOINTS          (JOINTS),
      .RATIO_FRAC_BITS (F)
   ) u_merge (
      .clock     (clock),
      .en        (rdy[F+1]),
      .ratio_in  (ratio_s),
      .value_in  (lane_v),
      .best_out  (best_s),
      .scale_out (scale_s),
      .value_out (mrg_v)
   );

   for (genvar j = 0; j < LANES; j++) begin : g_out
      if (j < JOINTS) begin : g_used
         vlus_scale #(
            .RATIO_FRAC_BITS (F)
         ) u_scale (
            .clock      (clock),
            .en         (rdy[F+3:F+2]),
            .best_in    (best_s),
            .scale_in   (scale_s),
            .value_in   (mrg_v[j]),
            .result_out (res_s[j])
         );
      end else begin : g_unused
         assign res_s[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[F+2]) begin
         scl_a_ff <= scale_s;
      end
      if (rdy[F+3]) begin
         scl_b_ff <= scl_a_ff;
      end
   end

   always_comb begin
      rsp_chan.payload.scaled_joint0 = res_s[0];
      rsp_chan.payload.scaled_joint1 = res_s[1];
      rsp_chan.payload.scaled_joint2 = res_s[2];
      rsp_chan.payload.was_scaled    = scl_b_ff;
   end

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&vld_ff) && !rsp_chan.ready)
      else $error("input blocked while pipeline has room");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted transfer lost at entry stage");

   a_limit_reset: assert property (@(posedge clock)
      reset |=> lim_ff[0] == LIMIT_MAX && lim_ff[1] == LIMIT_MAX && lim_ff[2] == LIMIT_MAX)
      else $error("limits not at maximum after reset");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector limit uniform scaler. A queue-fed driver
// sends joint vectors, in random bursts in some phases; a monitor predicts
// each scaled vector from its own copy of the joint limits and checks every
// result transfer in order, while the result side stalls on its own random
// pattern. Limits are rewritten between phases, extreme settings among them.
// ----------------------------------------------------------------------------
module tb_top;
   import vlus_pkg::*;

   localparam int JOINTS     = JOINTS_DEF;
   localparam int RATIO_FRAC = RATIO_FRAC_DEF;
   localparam int LATENCY    = RATIO_FRAC + 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0]   csr_wdata = '0;

   vlus_stream_if #(.payload_type(req_payload_type)) req_chan ();
   vlus_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   vector_limit_uniform_scaler_unit #(
      .JOINTS          (JOINTS),
      .RATIO_FRAC_BITS (RATIO_FRAC)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_payload_type    pending_vectors[$];
   rsp_payload_type    expected_scaled[$];
   logic [LIMIT_W-1:0] limit_copy[LANES];
   int                 error_count = 0;
   bit                 req_taken = 1'b0;
   bit                 bursty_sender = 1'b0;
   int                 burst_left = 1;
   int                 gap_left = 0;
   int                 stall_pct = 0;
   int                 ready_left = 0;
   bit                 ready_level = 1'b1;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      for (int i = 0; i < LANES; i++) limit_copy[i] = LIMIT_MAX;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_payload_type predict_scaled(input req_payload_type vec);
      logic signed [VALUE_W-1:0] vals[LANES];
      logic signed [VALUE_W-1:0] outs[LANES];
      longint unsigned           unity;
      longint unsigned           best;
      longint unsigned           mag;
      longint unsigned           ratio;
      longint unsigned           prod;
      bit                        scale;
      int                        sv;
      int                        res;
      rsp_payload_type           rsp;
      vals[0] = vec.value_joint0;
      vals[1] = vec.value_joint1;
      vals[2] = vec.value_joint2;
      unity = longint'(1) << RATIO_FRAC;
      best = unity;
      for (int i = 0; i < LANES && i < JOINTS; i++) begin
         sv = vals[i];
         mag = (sv < 0) ? -sv : sv;
         if (mag > 32767) mag = 32767;
         if (mag != 0) begin
            ratio = (longint'(limit_copy[i]) << RATIO_FRAC) / mag;
            if (ratio < best) best = ratio;
         end
      end
      scale = best < unity;
      for (int i = 0; i < LANES; i++) begin
         res = 0;
         if (i < JOINTS) begin
            sv = vals[i];
            if (scale) begin
               mag = (sv < 0) ? -sv : sv;
               prod = (mag * best) >> RATIO_FRAC;
               res = (sv < 0) ? -int'(prod) : int'(prod);
            end else begin
               res = sv;
            end
         end
         outs[i] = res[VALUE_W-1:0];
      end
      rsp.scaled_joint0 = outs[0];
      rsp.scaled_joint1 = outs[1];
      rsp.scaled_joint2 = outs[2];
      rsp.was_scaled    = scale;
      return rsp;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         error_count++;
         $display("%0t mismatch %s expected %0d actual %0d", $realtime, name,
                  exp_val, act_val);
      end
   endtask

   // driver: new transfer offered only once the previous one was taken
   always @(negedge clock) begin
      logic            next_valid;
      req_payload_type next_payload;
      next_valid   = req_chan.valid;
      next_payload = req_chan.payload;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_vectors.size() > 0) begin
            next_payload = pending_vectors.pop_front();
            next_valid   = 1'b1;
            if (bursty_sender) begin
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = $urandom_range(1, 8);
               end
            end
         end
      end
      req_chan.valid   <= next_valid;
      req_chan.payload <= next_payload;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (ready_left == 0) begin
            ready_level = ($urandom_range(0, 99) >= stall_pct);
            ready_left  = $urandom_range(1, 10);
         end
         ready_left--;
         rsp_chan.ready <= ready_level;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            expected_scaled = {expected_scaled, predict_scaled(req_chan.payload)};
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_scaled.size() == 0) begin
               error_count++;
               $display("%0t unexpected result transfer expected none actual %h",
                        $realtime, rsp_chan.payload);
            end else begin
               exp_rsp = expected_scaled.pop_front();
               check_field("scaled_joint0", exp_rsp.scaled_joint0,
                           rsp_chan.payload.scaled_joint0);
               check_field("scaled_joint1", exp_rsp.scaled_joint1,
                           rsp_chan.payload.scaled_joint1);
               check_field("scaled_joint2", exp_rsp.scaled_joint2,
                           rsp_chan.payload.scaled_joint2);
               check_field("was_scaled", exp_rsp.was_scaled, rsp_chan.payload.was_scaled);
            end
         end
         if (csr_we && csr_index < LANES) limit_copy[csr_index] = csr_wdata;
      end
   end

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[LIMIT_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_limits(input int lim0, input int lim1, input int lim2);
      write_limit(CSR_LIMIT_JOINT0, lim0);
      write_limit(CSR_LIMIT_JOINT1, lim1);
      write_limit(CSR_LIMIT_JOINT2, lim2);
   endtask

   task automatic push_vector(input int v0, input int v1, input int v2);
      req_payload_type vec;
      vec.value_joint0 = v0[VALUE_W-1:0];
      vec.value_joint1 = v1[VALUE_W-1:0];
      vec.value_joint2 = v2[VALUE_W-1:0];
      pending_vectors = {pending_vectors, vec};
   endtask

   task automatic wait_drained();
      while (pending_vectors.size() != 0 || req_chan.valid || expected_scaled.size() != 0)
         @(posedge clock);
   endtask

   function automatic int pick_limit(input int style);
      int lim;
      case (style)
         0: lim = $urandom_range(0, 32767);
         1: lim = $urandom_range(0, 4096);
         2: lim = $urandom_range(0, 1) ? 32767 : 0;
         default: lim = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1000);
      endcase
      return lim;
   endfunction

   function automatic int pick_value(input int lim);
      int mag;
      int val;
      case ($urandom_range(0, 9))
         0, 1: val = $signed($urandom_range(0, 65535) - 32768);
         2: val = 0;
         3: begin
            case ($urandom_range(0, 4))
               0: val = -32768;
               1: val = 32767;
               2: val = -32767;
               3: val = 1;
               default: val = -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1))
               mag = lim + $urandom_range(0, 64) - 32;
            else
               mag = $urandom_range(0, 2 * lim + 1);
            if (mag < 0) mag = 0;
            if (mag > 32768) mag = 32768;
            if ($urandom_range(0, 1)) val = -mag;
            else val = (mag > 32767) ? 32767 : mag;
         end
      endcase
      return val;
   endfunction

   initial begin
      int stall_levels[4] = '{0, 30, 60, 85};
      int lims[LANES];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits, extremes and the most negative value
      push_vector(0, 0, 0);
      push_vector(32767, 32767, 32767);
      push_vector(-32768, -32768, -32768);
      push_vector(-32768, 32767, 0);
      push_vector(1, -1, 0);
      push_vector(-1, 1, -32768);
      wait_drained();

      // zero limit on joint 2, joint limits met exactly
      set_limits(256, 1000, 0);
      write_limit(CSR_SPARE_INDEX, 5);
      push_vector(512, 0, 0);
      push_vector(0, 0, 0);
      push_vector(0, 2000, 0);
      push_vector(512, -2000, 0);
      push_vector(-32768, 0, 0);
      push_vector(32767, -32768, 0);
      push_vector(0, 0, 1);
      push_vector(100, 100, -5);
      push_vector(256, 1000, 0);
      push_vector(257, 0, 0);
      push_vector(-300, 500, 0);
      wait_drained();

      set_limits(0, 32767, 1);
      push_vector(1, 0, 0);
      push_vector(0, -32768, 0);
      push_vector(0, 0, -2);
      push_vector(0, 0, 0);
      push_vector(-32768, 32767, 32767);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         for (int i = 0; i < LANES; i++) lims[i] = pick_limit(p % 4);
         set_limits(lims[0], lims[1], lims[2]);
         if (p == 5) write_limit(CSR_SPARE_INDEX, $urandom_range(0, 32767));
         bursty_sender = (p % 3) != 0;
         stall_pct     = stall_levels[p % 4];
         for (int n = 0; n < 144; n++)
            push_vector(pick_value(lims[0]), pick_value(lims[1]), pick_value(lims[2]));
         wait_drained();
      end

      stall_pct = 0;
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_scaled.size() == 0) begin
         $display("vector_limit_uniform_scaler_unit verification clean");
      end else begin
         $display("vector_limit_uniform_scaler_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("vector_limit_uniform_scaler_unit verification failed");
      $finish;
   end

endmodule

// ===== vector_limit_uniform_scaler_unit.f =====
hw/rtl/vlus_pkg.sv
hw/rtl/vlus_stream_if.sv
hw/rtl/vlus_lane.sv
hw/rtl/vlus_merge.sv
hw/rtl/vlus_scale.sv
hw/rtl/vector_limit_uniform_scaler_unit.sv
bench/tb_top.sv
